// ----- rtl/fxalu_pkg.sv -----
// Package: opcodes, cell payload type and widths for the Q24.8 unit.
`default_nettype none
package fxalu_pkg;
  localparam int unsigned FracBits = 8;
  localparam int unsigned NumBits  = 32 + FracBits;  // dividend width, |a| shifted up
  localparam int unsigned DivCells = NumBits;        // one cell per quotient bit

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_MIN  = 4'd4, OP_MAX = 4'd5, OP_INC = 4'd6, OP_DEC = 4'd7,
    OP_FINT = 4'd8, OP_FFLT = 4'd9, OP_TINT = 4'd10, OP_TFLT = 4'd11,
    OP_CMP  = 4'd12
  } op_e;

  // Word travelling down the divider chain.
  typedef struct packed {
    logic                vld;
    logic [3:0]          kind;
    logic [31:0]         a;
    logic [31:0]         b;
    logic [31:0]         fin;
    logic [NumBits-1:0]  num;  // |a| shifted up by FracBits, quotient shifted in from the bottom
    logic [NumBits-1:0]  rem;
    logic [31:0]         den;  // |b|
    logic                neg;
  } cell_t;
endpackage
`default_nettype wire

// ----- rtl/fxalu_cell.sv -----
// One cell of the chain: a restoring divide step plus pass-along of the word.
`default_nettype none
module fxalu_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 en_i,
  input  fxalu_pkg::cell_t    d_i,
  output fxalu_pkg::cell_t    q_o
);
  fxalu_pkg::cell_t q_q, d_d;
  logic [fxalu_pkg::NumBits:0] trial;
  logic [fxalu_pkg::NumBits:0] sub;

  always_comb begin
    d_d   = d_i;
    trial = {d_i.rem, d_i.num[fxalu_pkg::NumBits-1]};
    sub   = trial - {{(fxalu_pkg::NumBits - 31){1'b0}}, d_i.den};
    d_d.num = {d_i.num[fxalu_pkg::NumBits-2:0], ~sub[fxalu_pkg::NumBits]};
    d_d.rem = sub[fxalu_pkg::NumBits] ? trial[fxalu_pkg::NumBits-1:0]
                                      : sub[fxalu_pkg::NumBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else if (en_i) begin
      q_q <= d_d;
    end
  end

  assign q_o = q_q;
endmodule
`default_nettype wire

// ----- rtl/fxalu_fin.sv -----
// Final stage: all non-divide operations and result formatting.
`default_nettype none
module fxalu_fin (
  input  wire              clk_i,
  input  wire              en_i,
  input  fxalu_pkg::cell_t d_i,
  output logic [71:0]      res_o
);
  logic signed [31:0] sa, sb;
  logic [31:0] fx, fl;
  logic lt, eq, gt, dz, re;
  logic signed [63:0] prod;
  logic [fxalu_pkg::NumBits-1:0] q;
  // from float
  logic [7:0] ex; logic [23:0] m; logic signed [9:0] sh; logic [63:0] mag;
  logic [5:0] r;
  // to float
  logic [31:0] amag; logic [4:0] p; logic [31:0] rem, half; logic [24:0] sig;
  logic [7:0] fex; logic [4:0] rs;

  assign sa = d_i.a;
  assign sb = d_i.b;

  always_comb begin
    fx = '0; fl = '0; lt = 1'b0; eq = 1'b0; gt = 1'b0; dz = 1'b0; re = 1'b0;
    prod = 64'(sa) * 64'(sb);
    q = d_i.neg ? ({fxalu_pkg::NumBits{1'b0}} - d_i.num) : d_i.num;
    ex = d_i.fin[30:23];
    m = (ex == 8'd0) ? {1'b0, d_i.fin[22:0]} : {1'b1, d_i.fin[22:0]};
    sh = ((ex == 8'd0) ? -10'sd149 : $signed({2'b0, ex}) - 10'sd150)
         + 10'(fxalu_pkg::FracBits);
    r = '0;
    if (sh >= 0) begin
      mag = (sh > 10'sd40) ? (64'd1 << 40) : (64'(m) << sh[5:0]);
    end else if (sh < -10'sd25) begin
      mag = '0;
    end else begin
      r = 6'(-sh);
      mag = (64'(m) + (64'd1 << (r - 6'd1))) >> r;
    end
    amag = d_i.a[31] ? (32'd0 - d_i.a) : d_i.a;
    p = '0;
    for (int i = 0; i < 32; i++) if (amag[i]) p = 5'(i);
    rs = (p > 5'd23) ? (p - 5'd23) : 5'd0;
    rem = amag & ((32'd1 << rs) - 32'd1);
    half = (rs == 5'd0) ? 32'd0 : (32'd1 << (rs - 5'd1));
    if (p <= 5'd23) begin
      sig = 25'(amag << (5'd23 - p));
      fex = 8'(p) + 8'(127 - fxalu_pkg::FracBits);
    end else begin
      sig = 25'(amag >> rs);
      if (rem > half || (rem == half && sig[0])) sig = sig + 25'd1;
      fex = 8'(p) + 8'(127 - fxalu_pkg::FracBits);
      if (sig[24]) begin
        sig = sig >> 1; fex = fex + 8'd1;
      end
    end
    case (d_i.kind)
      fxalu_pkg::OP_ADD:  fx = d_i.a + d_i.b;
      fxalu_pkg::OP_SUB:  fx = d_i.a - d_i.b;
      fxalu_pkg::OP_MUL:  fx = prod[31 + fxalu_pkg::FracBits : fxalu_pkg::FracBits];
      fxalu_pkg::OP_DIV:  if (d_i.b == '0) dz = 1'b1; else fx = q[31:0];
      fxalu_pkg::OP_MIN:  fx = (sa <= sb) ? d_i.a : d_i.b;
      fxalu_pkg::OP_MAX:  fx = (sa >= sb) ? d_i.a : d_i.b;
      fxalu_pkg::OP_INC:  fx = d_i.a + 32'd1;
      fxalu_pkg::OP_DEC:  fx = d_i.a - 32'd1;
      fxalu_pkg::OP_FINT: fx = d_i.a << fxalu_pkg::FracBits;
      fxalu_pkg::OP_FFLT: begin
        if (ex == 8'hFF) begin
          re = 1'b1;
          fx = (d_i.fin[22:0] != '0) ? 32'd0 : (d_i.fin[31] ? 32'h8000_0000 : 32'h7FFF_FFFF);
        end else if (ex == 8'd0 && d_i.fin[22:0] == '0) begin
          fx = '0;
        end else if (d_i.fin[31]) begin
          if (mag > 64'h8000_0000) begin re = 1'b1; fx = 32'h8000_0000; end
          else fx = 32'd0 - mag[31:0];
        end else begin
          if (mag > 64'h7FFF_FFFF) begin re = 1'b1; fx = 32'h7FFF_FFFF; end
          else fx = mag[31:0];
        end
      end
      fxalu_pkg::OP_TINT: fx = 32'(sa >>> fxalu_pkg::FracBits);
      fxalu_pkg::OP_TFLT: fl = (amag == '0) ? 32'd0 : {d_i.a[31], fex, sig[22:0]};
      fxalu_pkg::OP_CMP: begin lt = sa < sb; eq = sa == sb; gt = sa > sb; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_o <= {3'd0, re, dz, gt, eq, lt, fl, fx};
  end
endmodule
`default_nettype wire

// ----- rtl/fixed_point_q24_8_alu_core.sv -----
// Top level of the Q24.8 fixed-point arithmetic unit.
// Stateless Q24.8 unit, one word accepted per cycle unless the output stalls.
// Words pass one quotient bit per cell through a chain of
// 40 divide cells, then the registered final stage that holds every other
// operation. The whole pipe advances whenever the output register is empty
// or being taken, so a stalled output stalls intake.
`default_nettype none
module fixed_point_q24_8_alu_core (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [95:0]  s_axis_tdata,   // operand_a, operand_b, float_in
  input  wire  [3:0]   s_axis_tuser,   // kind
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [71:0]  m_axis_tdata    // fixed_result, float_result, lt, eq, gt, dz, re
);
  localparam int unsigned N = fxalu_pkg::DivCells;
  fxalu_pkg::cell_t c [0:N];
  logic en;
  logic vld_q;
  logic [71:0] res;
  logic [31:0] a, b;

  assign en = !vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign a = s_axis_tdata[31:0];
  assign b = s_axis_tdata[63:32];

  always_comb begin
    c[0].vld  = s_axis_tvalid;
    c[0].kind = s_axis_tuser;
    c[0].a    = a;
    c[0].b    = b;
    c[0].fin  = s_axis_tdata[95:64];
    c[0].num  = {(a[31] ? (32'd0 - a) : a), {fxalu_pkg::FracBits{1'b0}}};
    c[0].rem  = '0;
    c[0].den  = b[31] ? (32'd0 - b) : b;
    c[0].neg  = a[31] ^ b[31];
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    fxalu_cell u_cell (.clk_i, .rst_ni, .en_i(en), .d_i(c[g]), .q_o(c[g+1]));
  end

  fxalu_fin u_fin (.clk_i, .en_i(en), .d_i(c[N]), .res_o(res));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (en) vld_q <= c[N].vld;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = res;
endmodule
`default_nettype wire

// ----- rtl/fxalu_chk.sv -----
// Port checker for the Q24.8 unit.
`default_nettype none
module fxalu_chk (
  input wire clk_i, input wire rst_ni,
  input wire s_axis_tready,
  input wire m_axis_tvalid, input wire m_axis_tready,
  input wire [71:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)) else $error("hold");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("ready");
  a_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $countones(m_axis_tdata[66:64]) <= 1) else $error("cmp");
  a_dz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[67] |-> m_axis_tdata[31:0] == 32'd0) else $error("dz");
endmodule
bind fixed_point_q24_8_alu_core fxalu_chk u_chk (.clk_i, .rst_ni,
  .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);
`default_nettype wire
